// File: sv/mpl_pkg.sv
// Shared types and constants for the Markov packet loss model.
// Register index codes, reset values and the configuration struct.
// No dependencies.
package mpl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROB_W     = 32;
  localparam int FRAC_W     = 31;
  localparam int STATE_W    = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_PROBS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_01       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P_10       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P_12       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P_21       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P_23       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_P_32       = 3'd7;

  // Mode codes
  localparam logic MODE_TWO_STATE  = 1'b0;
  localparam logic MODE_FOUR_STATE = 1'b1;

  // Chain states (four-state naming; two-state uses GAP_LOSSY/GAP_LOSSLESS as gap/burst)
  localparam logic [STATE_W-1:0] ST_GAP_LOSSY      = 2'd0;
  localparam logic [STATE_W-1:0] ST_GAP_LOSSLESS   = 2'd1;
  localparam logic [STATE_W-1:0] ST_BURST_LOSSY    = 2'd2;
  localparam logic [STATE_W-1:0] ST_BURST_LOSSLESS = 2'd3;

  // Reset values
  localparam logic              RST_MODEL_MODE = MODE_FOUR_STATE;
  localparam logic [PROB_W-1:0] RST_GAP_LOSS   = 32'd0;
  localparam logic [PROB_W-1:0] RST_BURST_LOSS = 32'd0;
  localparam logic [PROB_W-1:0] RST_P_01       = 32'd2147483648;
  localparam logic [PROB_W-1:0] RST_P_10       = 32'd0;
  localparam logic [PROB_W-1:0] RST_P_12       = 32'd0;
  localparam logic [PROB_W-1:0] RST_P_21       = 32'd644245094;
  localparam logic [PROB_W-1:0] RST_P_23       = 32'd107374182;
  localparam logic [PROB_W-1:0] RST_P_32       = 32'd536870912;

  typedef struct packed {
    logic              model_mode;
    logic [PROB_W-1:0] gap_loss;
    logic [PROB_W-1:0] burst_loss;
    logic [PROB_W-1:0] p_01;
    logic [PROB_W-1:0] p_10;
    logic [PROB_W-1:0] p_12;
    logic [PROB_W-1:0] p_21;
    logic [PROB_W-1:0] p_23;
    logic [PROB_W-1:0] p_32;
  } cfg_t;

endpackage

// File: sv/mpl_cfg_regs.sv
// Configuration register file for the Markov packet loss model.
// Depends on mpl_pkg; flags writes to the mode register so the chain can clear.
module mpl_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mpl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mpl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mpl_pkg::cfg_t                  cfg,
  output logic                           mode_wr
);
  import mpl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    mode_wr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODEL_MODE: begin
          cfg_nxt.model_mode = cfg_wdata[0];
          mode_wr            = 1'b1;
        end
        REG_LOSS_PROBS: begin
          cfg_nxt.gap_loss   = cfg_wdata[31:0];
          cfg_nxt.burst_loss = cfg_wdata[63:32];
        end
        REG_P_01: cfg_nxt.p_01 = cfg_wdata[31:0];
        REG_P_10: cfg_nxt.p_10 = cfg_wdata[31:0];
        REG_P_12: cfg_nxt.p_12 = cfg_wdata[31:0];
        REG_P_21: cfg_nxt.p_21 = cfg_wdata[31:0];
        REG_P_23: cfg_nxt.p_23 = cfg_wdata[31:0];
        REG_P_32: cfg_nxt.p_32 = cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.model_mode <= RST_MODEL_MODE;
      cfg_r.gap_loss   <= RST_GAP_LOSS;
      cfg_r.burst_loss <= RST_BURST_LOSS;
      cfg_r.p_01       <= RST_P_01;
      cfg_r.p_10       <= RST_P_10;
      cfg_r.p_12       <= RST_P_12;
      cfg_r.p_21       <= RST_P_21;
      cfg_r.p_23       <= RST_P_23;
      cfg_r.p_32       <= RST_P_32;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/mpl_decide.sv
// Loss decision and next-state logic for one packet.
// Depends on mpl_pkg; pure combinational compares on the current chain state.
module mpl_decide #(
  parameter int PROB_BITS = 31
) (
  input  mpl_pkg::cfg_t                 cfg,
  input  logic [mpl_pkg::STATE_W-1:0]   state,
  input  logic [mpl_pkg::FRAC_W-1:0]    rand_loss,
  input  logic [mpl_pkg::FRAC_W-1:0]    rand_trans,
  output logic                          lost,
  output logic [mpl_pkg::STATE_W-1:0]   state_used,
  output logic [mpl_pkg::STATE_W-1:0]   state_nxt
);
  import mpl_pkg::*;

  localparam int SUM_W = PROB_W + 2;
  localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((33'd1 << PROB_BITS) - 33'd1);
  localparam logic [SUM_W-1:0]  ONE       = SUM_W'(34'd1 << PROB_BITS);

  logic [PROB_W-1:0] rl;
  logic [PROB_W-1:0] rt;
  logic              gap_hit;
  logic              burst_hit;
  logic              up_01;
  logic              le_01;
  logic              up_10;
  logic              up_12;
  logic              up_23;
  logic              up_32;
  logic              back_10;
  logic              back_21;
  logic              two_burst;

  assign rl = {1'b0, rand_loss & FRAC_MASK};
  assign rt = {1'b0, rand_trans & FRAC_MASK};

  assign gap_hit   = rl < cfg.gap_loss;
  assign burst_hit = rl < cfg.burst_loss;
  assign up_01     = rt < cfg.p_01;
  assign le_01     = rt <= cfg.p_01;
  assign up_10     = rt < cfg.p_10;
  assign up_12     = rt < cfg.p_12;
  assign up_23     = rt < cfg.p_23;
  assign up_32     = rt < cfg.p_32;
  // rt > ONE - p, done without going negative: rt + p > ONE
  assign back_10   = (SUM_W'(rt) + SUM_W'(cfg.p_10)) > ONE;
  assign back_21   = (SUM_W'(rt) + SUM_W'(cfg.p_21)) > ONE;
  assign two_burst = state[0];

  always_comb begin
    lost       = 1'b0;
    state_used = state;
    state_nxt  = state;
    if (cfg.model_mode == MODE_FOUR_STATE) begin
      unique case (state)
        ST_GAP_LOSSY: begin
          lost = gap_hit;
          if (le_01) state_nxt = ST_GAP_LOSSLESS;
        end
        ST_GAP_LOSSLESS: begin
          if (up_12)        state_nxt = ST_BURST_LOSSY;
          else if (back_10) state_nxt = ST_GAP_LOSSY;
        end
        ST_BURST_LOSSY: begin
          lost = burst_hit;
          if (up_23)        state_nxt = ST_BURST_LOSSLESS;
          else if (back_21) state_nxt = ST_GAP_LOSSLESS;
        end
        default: begin
          if (up_32) state_nxt = ST_BURST_LOSSY;
        end
      endcase
    end else begin
      state_used = {1'b0, two_burst};
      lost       = two_burst ? burst_hit : gap_hit;
      if (two_burst ? up_10 : up_01) state_nxt = {1'b0, ~two_burst};
      else                           state_nxt = {1'b0, two_burst};
    end
  end

endmodule

// File: sv/markov_packet_loss_model.sv
// Top level of the Markov packet loss model (Gilbert-Elliott / four-state gap-burst).
// Depends on mpl_pkg, mpl_cfg_regs and mpl_decide.
//
// One input item is one packet carrying two random fractions; one result item
// per packet reports whether it is lost and the chain state it was judged in.
// Throughput is one packet per clock while results are taken: the item sits in an
// input register, the decision and next chain state come from a few compares, and
// the result lands in an output register while the 2-bit chain state updates at the
// same edge. The result is offered once it has moved from the input register to
// the output register; a held result stalls input.
// Writing the mode register (any value) returns the chain to the gap state.
// Probabilities are unsigned fractions where 2^PROB_BITS stands for 1.0.
module markov_packet_loss_model #(
  parameter int PROB_BITS = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config
  input  logic                            cfg_we,
  input  logic [mpl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mpl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // packets in
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mpl_pkg::IN_DATA_W-1:0]   in_tdata,   // [30:0] rand_loss, [61:31] rand_trans
  // results out
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mpl_pkg::OUT_DATA_W-1:0]  out_tdata   // [0] lost, [2:1] chain_state_used
);
  import mpl_pkg::*;

  cfg_t              cfg;
  logic              mode_wr;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [FRAC_W-1:0] rand_loss_r;
  logic [FRAC_W-1:0] rand_trans_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              lost_r;
  logic [STATE_W-1:0] used_r;
  logic [STATE_W-1:0] chain_state_r;
  logic [STATE_W-1:0] chain_state_nxt;

  logic              lost_c;
  logic [STATE_W-1:0] used_c;
  logic [STATE_W-1:0] state_c;
  logic              advance;
  logic              in_acc;

  mpl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .mode_wr   (mode_wr)
  );

  mpl_decide #(.PROB_BITS(PROB_BITS)) u_decide (
    .cfg        (cfg),
    .state      (chain_state_r),
    .rand_loss  (rand_loss_r),
    .rand_trans (rand_trans_r),
    .lost       (lost_c),
    .state_used (used_c),
    .state_nxt  (state_c)
  );

  // stage 1 moves on when the output register is empty or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)       s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;

    chain_state_nxt = chain_state_r;
    if (mode_wr)      chain_state_nxt = ST_GAP_LOSSY;
    else if (advance) chain_state_nxt = state_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      chain_state_r <= ST_GAP_LOSSY;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      chain_state_r <= chain_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rand_loss_r  <= in_tdata[FRAC_W-1:0];
      rand_trans_r <= in_tdata[2*FRAC_W-1:FRAC_W];
    end
    if (advance) begin
      lost_r <= lost_c;
      used_r <= used_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1-STATE_W){1'b0}}, used_r, lost_r};

endmodule
